### hw/rtl/tdfa_pkg.sv
`default_nettype none
package tdfa_pkg;

    // Automaton dimensions
    localparam int MAX_STATES  = 16;
    localparam int MAX_SYMBOLS = 16;

    // Fixed field widths
    localparam int STATE_CW = 5;
    localparam int ROW_W    = 4;
    localparam int SLOT_FW  = 4;
    localparam int BYTE_W   = 8;
    localparam int START_W  = 4;
    localparam int MASK_W   = 16;
    localparam int COUNT_W  = 5;
    localparam int CFG_DW   = 16;
    localparam int CFG_IW   = 2;

    // Derived storage sizes
    localparam int SLOT_W    = $clog2(MAX_SYMBOLS);
    localparam int TBL_DEPTH = MAX_STATES * MAX_SYMBOLS;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);

    localparam logic [STATE_CW-1:0] STUCK_CODE = 5'd16;

    typedef enum logic [1:0] {
        ACT_WRITE_TRANS = 2'd0,
        ACT_WRITE_ALPHA = 2'd1,
        ACT_FEED        = 2'd2,
        ACT_END_WORD    = 2'd3
    } action_t;

    typedef enum logic [0:0] {
        KIND_STEP    = 1'b0,
        KIND_VERDICT = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        VERDICT_REJECTED = 2'd0,
        VERDICT_ACCEPTED = 2'd1,
        VERDICT_STUCK    = 2'd2,
        VERDICT_INVALID  = 2'd3
    } verdict_t;

    typedef enum logic [CFG_IW-1:0] {
        CFG_START_STATE  = 2'd0,
        CFG_ACCEPT_MASK  = 2'd1,
        CFG_SYMBOL_COUNT = 2'd2
    } cfg_index_t;

    typedef logic [BYTE_W-1:0] alpha_arr_t [MAX_SYMBOLS];

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
    } match_t;

    function automatic logic [TBL_AW-1:0] tbl_addr(input logic [STATE_CW-1:0] state,
                                                   input logic [SLOT_W-1:0]   slot);
        tbl_addr = TBL_AW'(32'(state) * MAX_SYMBOLS + 32'(slot));
    endfunction

endpackage
`default_nettype wire

### hw/rtl/tdfa_item_if.sv
`default_nettype none
interface tdfa_item_if;
    import tdfa_pkg::*;

    logic                    valid;
    logic                    ready;
    action_t                 action;
    logic [ROW_W-1:0]        row_state;
    logic [SLOT_FW-1:0]      symbol_slot;
    logic [STATE_CW-1:0]     target_state;
    logic [BYTE_W-1:0]       symbol_byte;

    modport source (
        output valid, action, row_state, symbol_slot, target_state, symbol_byte,
        input  ready
    );

    modport sink (
        input  valid, action, row_state, symbol_slot, target_state, symbol_byte,
        output ready
    );
endinterface
`default_nettype wire

### hw/rtl/tdfa_result_if.sv
`default_nettype none
interface tdfa_result_if;
    import tdfa_pkg::*;

    logic                valid;
    logic                ready;
    kind_t               result_kind;
    logic [STATE_CW-1:0] state_before;
    verdict_t            verdict;

    modport source (
        output valid, result_kind, state_before, verdict,
        input  ready
    );

    modport sink (
        input  valid, result_kind, state_before, verdict,
        output ready
    );
endinterface
`default_nettype wire

### hw/rtl/tdfa_ram.sv
`default_nettype none
module tdfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### hw/rtl/tdfa_match.sv
`default_nettype none
module tdfa_match (
    input  wire tdfa_pkg::alpha_arr_t             codes,
    input  wire logic [tdfa_pkg::COUNT_W-1:0]     symbol_count,
    input  wire logic [tdfa_pkg::BYTE_W-1:0]      symbol_byte,
    output tdfa_pkg::match_t                      match
);
    import tdfa_pkg::*;

    logic [MAX_SYMBOLS-1:0] hit;

    // Compare against every active slot in parallel
    always_comb
    begin
        for (int k = 0; k < MAX_SYMBOLS; k++)
        begin
            hit[k] = (k < 32'(symbol_count)) && (codes[k] == symbol_byte);
        end
    end

    // Lowest matching slot wins
    always_comb
    begin
        match.found = |hit;
        match.slot  = '0;
        for (int k = MAX_SYMBOLS - 1; k >= 0; k--)
        begin
            if (hit[k])
            begin
                match.slot = SLOT_W'(k);
            end
        end
    end
endmodule
`default_nettype wire

### hw/rtl/table_driven_dfa_matcher.sv
`default_nettype none
// Table-driven DFA matcher.
// Items arrive on the item channel (valid/ready); a transfer takes place at a
// rising edge with valid and ready high. Load items write one transition
// entry or one alphabet code and return nothing. A feed item matches its byte
// against the active alphabet slots, steps the automaton and returns a step
// trace holding the state before the step. An end-of-word item returns the
// verdict and reloads the start state. Results leave on the result channel.
// Registers start_state, accept_mask and symbol_count are written through the
// plain cfg port; the user must write them only while the block is idle, and
// the block does not enforce it. Results are registered: a result appears in
// the cycle after its transfer. One item per cycle unless the receiver stalls.
// The transition table is a synchronous RAM read once per feed item; its read
// data is forwarded into the next lookup address: symbols step back to back.
// Reset: the automaton sits in state 0 with both latches clear; the table and
// the alphabet are undefined until loaded. There is no clearing pass.
// Stall: the result register holds while the receiver stalls; a new item is
// taken in the same cycle the held result is transferred.
module table_driven_dfa_matcher (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [tdfa_pkg::CFG_IW-1:0]     cfg_index,
    input  wire logic [tdfa_pkg::CFG_DW-1:0]     cfg_data,
    tdfa_item_if.sink                            item,
    tdfa_result_if.source                        result
);
    import tdfa_pkg::*;

    // Configuration registers
    logic [START_W-1:0] start_reg;
    logic [MASK_W-1:0]  mask_reg;
    logic [COUNT_W-1:0] count_reg;

    // Automaton state
    logic [STATE_CW-1:0] cur_reg, cur_next;
    logic                pending_reg, pending_next;
    logic                stuck_reg, stuck_next;
    logic                invalid_reg, invalid_next;

    // Alphabet codes: each compared at its own slot, written at one slot
    alpha_arr_t          alpha_reg;

    // Result register
    logic                out_valid_reg, out_valid_next;
    kind_t               out_kind_reg, out_kind_next;
    logic [STATE_CW-1:0] out_state_reg, out_state_next;
    verdict_t            out_verdict_reg, out_verdict_next;

    logic                accept;
    logic                out_load;
    logic [STATE_CW-1:0] eff_state;
    logic                eff_stuck;
    logic                eff_accepts;
    logic [STATE_CW-1:0] start_code;
    logic [STATE_CW-1:0] target_code;
    logic [SLOT_W-1:0]   slot_idx;
    logic                row_ok;
    logic                slot_ok;
    logic                lookup;
    match_t              match;

    logic                tbl_we;
    logic [TBL_AW-1:0]   tbl_waddr;
    logic [TBL_AW-1:0]   tbl_raddr;
    logic [STATE_CW-1:0] tbl_rdata;

    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    // Forward the table read of the previous step as the current state
    assign eff_state   = pending_reg ? tbl_rdata : cur_reg;
    assign eff_stuck   = (eff_state >= STUCK_CODE) || (32'(eff_state) >= MAX_STATES);
    assign eff_accepts = !eff_stuck && mask_reg[eff_state[START_W-1:0]];

    assign start_code  = (32'(start_reg) >= MAX_STATES) ? STUCK_CODE
                                                        : STATE_CW'(start_reg);
    assign target_code = ((item.target_state >= STUCK_CODE)
                          || (32'(item.target_state) >= MAX_STATES))
                         ? STUCK_CODE : item.target_state;

    assign slot_idx = SLOT_W'(item.symbol_slot);
    assign row_ok   = 32'(item.row_state) < MAX_STATES;
    assign slot_ok  = 32'(item.symbol_slot) < MAX_SYMBOLS;

    tdfa_match u_match (
        .codes        (alpha_reg),
        .symbol_count (count_reg),
        .symbol_byte  (item.symbol_byte),
        .match        (match)
    );

    // A valid symbol from a live state reads its successor from the table
    assign lookup = accept && (item.action == ACT_FEED) && !invalid_reg
                    && !eff_stuck && match.found;

    assign tbl_raddr = tbl_addr(eff_state, match.slot);
    assign tbl_we    = accept && (item.action == ACT_WRITE_TRANS) && row_ok && slot_ok;
    assign tbl_waddr = tbl_addr(STATE_CW'(item.row_state), slot_idx);

    tdfa_ram #(
        .WIDTH (STATE_CW),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (target_code),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // Next automaton state and latches
    always_comb
    begin
        cur_next     = eff_state;
        pending_next = 1'b0;
        stuck_next   = stuck_reg;
        invalid_next = invalid_reg;
        if (accept)
        begin
            case (item.action)
                ACT_FEED:
                begin
                    if (!invalid_reg)
                    begin
                        if (eff_stuck)
                        begin
                            stuck_next = 1'b1;
                            cur_next   = STUCK_CODE;
                        end
                        else if (!match.found)
                        begin
                            invalid_next = 1'b1;
                        end
                        else
                        begin
                            pending_next = 1'b1;
                        end
                    end
                end
                ACT_END_WORD:
                begin
                    cur_next     = start_code;
                    stuck_next   = 1'b0;
                    invalid_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result register: load on a feed or end-of-word transfer, hold while stalled
    assign out_load = accept && ((item.action == ACT_FEED) || (item.action == ACT_END_WORD));

    always_comb
    begin
        out_valid_next   = out_load || (out_valid_reg && !result.ready);
        out_kind_next    = out_kind_reg;
        out_state_next   = out_state_reg;
        out_verdict_next = out_verdict_reg;
        if (out_load)
        begin
            out_state_next = eff_state;
            if (item.action == ACT_END_WORD)
            begin
                out_kind_next = KIND_VERDICT;
                if (invalid_reg)
                begin
                    out_verdict_next = VERDICT_INVALID;
                end
                else if (stuck_reg)
                begin
                    out_verdict_next = VERDICT_STUCK;
                end
                else if (eff_accepts)
                begin
                    out_verdict_next = VERDICT_ACCEPTED;
                end
                else
                begin
                    out_verdict_next = VERDICT_REJECTED;
                end
            end
            else
            begin
                out_kind_next    = KIND_STEP;
                out_verdict_next = VERDICT_REJECTED;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.result_kind  = out_kind_reg;
    assign result.state_before = out_state_reg;
    assign result.verdict      = out_verdict_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            pending_reg   <= 1'b0;
            stuck_reg     <= 1'b0;
            invalid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_reg       <= cur_next;
            pending_reg   <= pending_next;
            stuck_reg     <= stuck_next;
            invalid_reg   <= invalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            mask_reg  <= '0;
            count_reg <= COUNT_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_STATE:  start_reg <= cfg_data[START_W-1:0];
                CFG_ACCEPT_MASK:  mask_reg  <= cfg_data[MASK_W-1:0];
                CFG_SYMBOL_COUNT: count_reg <= cfg_data[COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Payload: alphabet codes and result fields
    always_ff @(posedge clk)
    begin
        if (accept && (item.action == ACT_WRITE_ALPHA) && slot_ok)
        begin
            alpha_reg[slot_idx] <= item.symbol_byte;
        end
        out_kind_reg    <= out_kind_next;
        out_state_reg   <= out_state_next;
        out_verdict_reg <= out_verdict_next;
    end

    // A result is loaded only when the result register is free or draining
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || result.ready))
        else $error("result overwritten while held");

    // A table lookup is only issued from a live state
    a_lookup_live: assert property (@(posedge clk) disable iff (!rst_n)
        lookup |-> (eff_state < STUCK_CODE))
        else $error("table lookup from stuck state");

    // Once invalid, symbols do not step the automaton
    a_invalid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && invalid_reg && (item.action == ACT_FEED)) |=>
            (!pending_reg && invalid_reg && (cur_reg == $past(eff_state))))
        else $error("state moved while invalid latch set");

    // End of word clears both latches
    a_word_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.action == ACT_END_WORD)) |=> (!stuck_reg && !invalid_reg))
        else $error("latches survive end of word");

    // A step trace always carries the rejected code
    a_step_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg == KIND_STEP)) |-> (out_verdict_reg == VERDICT_REJECTED))
        else $error("step trace with non-zero verdict");

endmodule
`default_nettype wire
